/* src/assert_macros.svh */
// assertion macros used by the top-level rtl file
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/dmm_pkg.sv */
// shared constants, command codes and queue entry type for the matrix multiplier
// no dependencies
package dmm_pkg;

  localparam int MAX_DIM_DEF   = 32;
  localparam int ELEM_BITS_DEF = 16;
  localparam int CFG_W         = 6;
  localparam int N_W           = 7;
  localparam int RES_W         = 40;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] value;
  } cmd_t;

  function automatic logic [N_W-1:0] eff_size(input logic [CFG_W-1:0] cfg, input int max_dim);
    logic [N_W-1:0] n;
    n = N_W'(cfg);
    if (n == '0) begin
      n = N_W'(1);
    end
    if (int'(n) > max_dim) begin
      n = N_W'(max_dim);
    end
    return n;
  endfunction

endpackage

/* src/dmm_front.sv */
// front end: unpacks input beats, drops out-of-range or unused items, feeds the queue
// depends on dmm_pkg
module dmm_front import dmm_pkg::*; (
  input  logic [N_W-1:0] n_eff,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [31:0]    s_tdata,   // row_index[4:0], col_index[9:5], element_value[25:10]
  input  logic [1:0]     s_tuser,   // command[1:0]
  input  logic           q_full,
  output logic           q_push,
  output cmd_t           q_entry
);

  logic row_ok;
  logic col_ok;
  logic keep;

  always_comb begin
    q_entry.cmd   = s_tuser;
    q_entry.row   = s_tdata[4:0];
    q_entry.col   = s_tdata[9:5];
    q_entry.value = s_tdata[25:10];
  end

  assign row_ok = N_W'(q_entry.row) < n_eff;
  assign col_ok = N_W'(q_entry.col) < n_eff;

  always_comb begin
    unique case (q_entry.cmd) inside
      CMD_LOAD_A, CMD_LOAD_B: keep = row_ok && col_ok;
      CMD_COMPUTE:            keep = row_ok;
      default:                keep = 1'b0;
    endcase
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && keep;

endmodule

/* src/dmm_queue.sv */
// small command queue between front and back end
// depends on dmm_pkg
module dmm_queue import dmm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_entry,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = count == FULL_CNT;
  assign pop_valid = count != '0;
  assign pop_entry = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* src/dmm_back.sv */
// back end: element stores, one multiply-accumulate lane per result column, output register
// depends on dmm_pkg
module dmm_back import dmm_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [N_W-1:0] n_eff,
  input  logic           q_valid,
  input  cmd_t           q_entry,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [47:0]    m_tdata,   // result_value[39:0], result_column[44:40]
  output logic           m_tlast    // last_in_row
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(MAX_DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] row;

  logic                        issue;
  logic                        rd_v;
  logic                        prod_v;
  logic                        start;
  logic                        load_a;
  logic                        load_b;
  logic                        out_load;
  logic                        out_valid;
  logic signed [RES_W-1:0]     out_value;
  logic [4:0]                  out_col;
  logic                        out_last;
  logic signed [ELEM_BITS-1:0] ev;
  logic [ADDR_W-1:0]           wr_addr;
  logic [ADDR_W-1:0]           rd_addr;

  logic signed [ELEM_BITS-1:0] a_mem [DEPTH];
  logic signed [ELEM_BITS-1:0] a_rd;
  logic signed [ELEM_BITS-1:0] b_rd [MAX_DIM];
  logic signed [PROD_W-1:0]    prod [MAX_DIM];
  logic signed [RES_W-1:0]     acc  [MAX_DIM];

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign start    = q_pop && (q_entry.cmd == CMD_COMPUTE);
  assign load_a   = q_pop && (q_entry.cmd == CMD_LOAD_A);
  assign load_b   = q_pop && (q_entry.cmd == CMD_LOAD_B);
  assign issue    = state == ST_ISSUE;
  assign out_load = (state == ST_DRAIN) && (!out_valid || m_tready);

  assign ev      = ELEM_BITS'(q_entry.value);
  assign wr_addr = ADDR_W'(ADDR_W'(q_entry.row) * DIM_A) + ADDR_W'(q_entry.col);
  assign rd_addr = ADDR_W'(ADDR_W'(row) * DIM_A) + ADDR_W'(k);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_ISSUE;
      ST_ISSUE: if (N_W'(k) == n_eff - N_W'(1)) state_next = ST_FLUSH;
      ST_FLUSH: if (!rd_v && !prod_v) state_next = ST_DRAIN;
      ST_DRAIN: if (out_load && (N_W'(j) == n_eff - N_W'(1))) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
      k      <= '0;
      j      <= '0;
      row    <= '0;
    end else begin
      state  <= state_next;
      rd_v   <= issue;
      prod_v <= rd_v;
      if (start) begin
        row <= IDX_W'(q_entry.row);
        k   <= '0;
      end else if (issue) begin
        k <= k + IDX_W'(1);
      end
      if (state == ST_FLUSH) begin
        j <= '0;
      end else if (out_load) begin
        j <= j + IDX_W'(1);
      end
    end
  end

  // a store: one element per cycle along the selected row
  always_ff @(posedge clk) begin
    if (load_a) begin
      a_mem[wr_addr] <= ev;
    end
    if (issue) begin
      a_rd <= a_mem[rd_addr];
    end
  end

  for (genvar lane = 0; lane < MAX_DIM; lane++) begin : g_lane
    logic signed [ELEM_BITS-1:0] bank [MAX_DIM];

    // b column bank for this result column
    always_ff @(posedge clk) begin
      if (load_b && (N_W'(q_entry.col) == N_W'(lane))) begin
        bank[IDX_W'(q_entry.row)] <= ev;
      end
      if (issue) begin
        b_rd[lane] <= bank[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rd_v) begin
        prod[lane] <= PROD_W'(a_rd) * PROD_W'(b_rd[lane]);
      end
    end

    // accumulate, then shift toward lane 0 while draining
    always_ff @(posedge clk) begin
      if (start) begin
        acc[lane] <= '0;
      end else if (prod_v) begin
        acc[lane] <= acc[lane] + RES_W'(prod[lane]);
      end else if (out_load) begin
        if (lane == MAX_DIM - 1) begin
          acc[lane] <= '0;
        end else begin
          acc[lane] <= acc[(lane + 1) % MAX_DIM];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= acc[0];
      out_col   <= 5'(j);
      out_last  <= N_W'(j) == n_eff - N_W'(1);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_col, out_value};
  assign m_tlast  = out_last;

endmodule

/* src/dense_matrix_multiply_top.sv */
// dense square matrix multiplier, top level: size register, front end, queue, back end
// depends on dmm_pkg, dmm_front, dmm_queue, dmm_back and assert_macros.svh
// usage:
//   s_* channel takes one command per beat: command in s_tuser, row, column and
//   element in s_tdata. load a and load b write one element; compute emits row r of
//   c = a x b on the m_* channel, one 40-bit sum per column in ascending order,
//   m_tlast on the last column. loads with row or column at or beyond the size are
//   dropped, as are compute items with row at or beyond it and the unused command code.
//   cfg_we / cfg_wdata set the matrix size n (0 acts as 1, above MAX_DIM as MAX_DIM);
//   write it only while the block is idle.
// timing:
//   a load is written to its store as it leaves the queue. a compute leaves the
//   queue, reads the a row and all b columns at one inner index per cycle with one
//   multiply-accumulate lane per column, flushes the read and product registers,
//   then sends n result beats at one per cycle, holding while m_tready is low.
//   a four-entry queue between front and back end keeps accepting items while a
//   compute runs or a result waits. when m_tready is low the result holds in the
//   output register and the queue fills, then s_tready drops.
// reset:
//   synchronous rst empties the queue and output, restores size 32; stores keep contents
`include "assert_macros.svh"

module dense_matrix_multiply_top import dmm_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // row_index[4:0], col_index[9:5], element_value[25:10]
  input  logic [1:0]       s_tuser,   // command[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [47:0]      m_tdata,   // result_value[39:0], result_column[44:40]
  output logic             m_tlast,   // last_in_row
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] matrix_size;
  logic [N_W-1:0]   n_eff;
  logic             q_full;
  logic             q_push;
  cmd_t             q_in;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_out;
  logic [4:0]       m_col;
  logic [4:0]       last_col;
  logic             m_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_we) begin
      matrix_size <= cfg_wdata;
    end
  end

  assign n_eff = eff_size(matrix_size, MAX_DIM);

  dmm_front u_front (
    .n_eff    (n_eff),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  dmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_out)
  );

  dmm_back #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .n_eff    (n_eff),
    .q_valid  (q_valid),
    .q_entry  (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  assign m_col    = m_tdata[44:40];
  assign last_col = 5'(n_eff - N_W'(1));
  assign m_beat   = m_tvalid && m_tready;

  `ASSERT_CLK(a_last_col, m_tvalid && m_tlast |-> m_col == last_col, "tlast not on last column")
  `ASSERT_CLK(a_col_step, m_beat && !m_tlast |=> m_tvalid && m_col == $past(m_col) + 5'd1, "col skip")
  `ASSERT_ALWAYS(a_rst_out, rst |=> !m_tvalid, "output valid after reset")

endmodule

/* tb/dmm_checker.sv */
// result checker for the dense matrix multiplier: watches the command, result and size ports
// keeps its own size register and element stores and compares every result beat in order
// depends on dmm_pkg
module dmm_checker import dmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [31:0]      s_tdata,   // row_index[4:0], col_index[9:5], element_value[25:10]
  input  logic [1:0]       s_tuser,   // command[1:0]
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [47:0]      m_tdata,   // result_value[39:0], result_column[44:40]
  input  logic             m_tlast,   // last_in_row
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               failures,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [RES_W-1:0] sum;
    logic [4:0]       column;
    logic             last;
  } c_elem_t;

  logic [CFG_W-1:0]   size_reg;
  logic signed [15:0] a_mat [MAX_DIM_DEF*MAX_DIM_DEF];
  logic signed [15:0] b_mat [MAX_DIM_DEF*MAX_DIM_DEF];
  c_elem_t            c_row_q [$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic int active_dim(input logic [CFG_W-1:0] sz);
    int n;
    n = int'(sz);
    if (n == 0) n = 1;
    if (n > MAX_DIM_DEF) n = MAX_DIM_DEF;
    return n;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t ns result mismatch: %s", $time, what);
    failures++;
  endtask

  task automatic push_c_row(input int row, input int n);
    c_elem_t e;
    longint  acc;
    for (int j = 0; j < n; j++) begin
      acc = 0;
      for (int k = 0; k < n; k++) begin
        acc += longint'(a_mat[row*MAX_DIM_DEF+k]) * longint'(b_mat[k*MAX_DIM_DEF+j]);
      end
      e.sum    = acc[RES_W-1:0];
      e.column = j[4:0];
      e.last   = (j == n - 1);
      c_row_q.push_back(e);
    end
  endtask

  task automatic take_command(input logic [1:0] cmd, input int row, input int col,
                              input logic signed [15:0] value);
    int n;
    n = active_dim(size_reg);
    if (row >= n) return;
    if (cmd == CMD_COMPUTE) begin
      push_c_row(row, n);
    end else if (col < n) begin
      if (cmd == CMD_LOAD_A) a_mat[row*MAX_DIM_DEF+col] = value;
      else if (cmd == CMD_LOAD_B) b_mat[row*MAX_DIM_DEF+col] = value;
    end
  endtask

  task automatic check_beat();
    c_elem_t e;
    if (c_row_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat, column %0d", m_tdata[44:40]));
      return;
    end
    e = c_row_q.pop_front();
    if (m_tdata[RES_W-1:0] !== e.sum)
      flag_mismatch($sformatf("column %0d sum %0d, want %0d", e.column,
                              $signed(m_tdata[RES_W-1:0]), $signed(e.sum)));
    if (m_tdata[44:40] !== e.column)
      flag_mismatch($sformatf("column %0d, want %0d", m_tdata[44:40], e.column));
    if (m_tlast !== e.last)
      flag_mismatch($sformatf("column %0d tlast %b, want %b", e.column, m_tlast, e.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      size_reg = SIZE_RESET;
      c_row_q.delete();
    end else begin
      if (cfg_we) size_reg = cfg_wdata;
      if (m_tvalid && m_tready) check_beat();
      if (s_tvalid && s_tready)
        take_command(s_tuser, int'(s_tdata[4:0]), int'(s_tdata[9:5]), s_tdata[25:10]);
    end
    pending = c_row_q.size();
  end

endmodule

/* tb/tb_dense_matrix_multiply_top.sv */
// testbench top for dense_matrix_multiply_top: clock, reset, command stimulus, result sink
// loads the element stores, computes rows at several matrix sizes, checks through dmm_checker
// depends on dmm_pkg, dmm_checker and the rtl
module tb_dense_matrix_multiply_top;
  import dmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;
  logic [1:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [47:0]      m_tdata;
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               failures;
  int               pending;

  logic [31:0] a_loaded [32];
  logic [31:0] b_loaded [32];
  int          cur_n = 32;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  always #10 clk = ~clk;

  dense_matrix_multiply_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  dmm_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  function automatic logic [15:0] elem_pick();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input int row, input int col,
                           input logic [15:0] val);
    int gap;
    @(negedge clk);
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, val, col[4:0], row[4:0]};
    if (row < cur_n && col < cur_n) begin
      if (cmd == CMD_LOAD_A) a_loaded[row][col] = 1'b1;
      if (cmd == CMD_LOAD_B) b_loaded[row][col] = 1'b1;
    end
    do @(posedge clk); while (!s_tready);
  endtask

  // fill in every a row and b entry the row product reads that is still unwritten, then send the compute
  task automatic compute_row(input int row);
    for (int k = 0; k < cur_n; k++) begin
      if (!a_loaded[row][k]) send_item(CMD_LOAD_A, row, k, elem_pick());
      for (int j = 0; j < cur_n; j++) begin
        if (!b_loaded[k][j]) send_item(CMD_LOAD_B, k, j, elem_pick());
      end
    end
    send_item(CMD_COMPUTE, row, $urandom_range(0, 31), 16'($urandom));
  endtask

  task automatic set_size(input logic [CFG_W-1:0] sz);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sz;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_n = (sz == 0) ? 1 : (sz > 32) ? 32 : int'(sz);
  endtask

  task automatic random_item();
    int pick;
    int row;
    int col;
    logic [1:0] cmd;
    pick = $urandom_range(0, 99);
    row  = $urandom_range(0, cur_n - 1);
    col  = $urandom_range(0, cur_n - 1);
    if (pick < 35) begin
      send_item(CMD_LOAD_A, row, col, elem_pick());
    end else if (pick < 55) begin
      send_item(CMD_LOAD_B, row, col, elem_pick());
    end else if (pick < 85) begin
      // large sizes would need the whole b store written first
      if (cur_n <= 4) compute_row(row);
      else send_item(CMD_LOAD_A, row, col, elem_pick());
    end else if (pick < 95 && cur_n < 32) begin
      cmd = 2'($urandom_range(0, 2));
      if (cmd == CMD_COMPUTE || $urandom_range(0, 1) == 0) row = $urandom_range(cur_n, 31);
      else col = $urandom_range(cur_n, 31);
      send_item(cmd, row, col, elem_pick());
    end else begin
      send_item(CMD_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31), 16'($urandom));
    end
  endtask

  initial begin
    int gap;
    bit rx_quiet;
    rx_quiet = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 24) == 0) rx_quiet = !rx_quiet;
        gap = rx_quiet ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    logic [CFG_W-1:0] sizes [11] = '{6'd1, 6'd0, 6'd63, 6'd5, 6'd33, 6'd4,
                                     6'd17, 6'd3, 6'd31, 6'd32, 6'd2};
    for (int r = 0; r < 32; r++) begin
      a_loaded[r] = '0;
      b_loaded[r] = '0;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // size 2: extremes, out-of-range items and the unused command
    set_size(6'd2);
    send_item(CMD_LOAD_A, 0, 0, 16'h8000);
    send_item(CMD_LOAD_B, 0, 0, 16'h8000);
    send_item(CMD_LOAD_A, 1, 1, 16'h7fff);
    send_item(CMD_LOAD_B, 1, 1, 16'h8000);
    send_item(CMD_LOAD_B, 0, 1, 16'h7fff);
    send_item(CMD_LOAD_A, 2, 0, 16'h1234);
    send_item(CMD_LOAD_B, 0, 5, 16'h4321);
    send_item(CMD_COMPUTE, 2, 0, 16'h0000);
    compute_row(1);
    compute_row(0);
    send_item(CMD_UNUSED, 0, 0, 16'h0000);

    foreach (sizes[p]) begin
      set_size(sizes[p]);
      quiet = ($urandom_range(0, 3) == 0);
      if (sizes[p] == 6'd4) begin
        hold_req = 1'b1;
        quiet = 1'b1;
        repeat (10) compute_row($urandom_range(0, 3));
        quiet = 1'b0;
      end
      repeat (5) random_item();
    end
    quiet = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (failures == 0) begin
      $display("dense_matrix_multiply_top regression: pass");
    end else begin
      $display("dense_matrix_multiply_top regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("dense_matrix_multiply_top regression: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/dmm_pkg.sv
src/dmm_front.sv
src/dmm_queue.sv
src/dmm_back.sv
src/dense_matrix_multiply_top.sv
tb/dmm_checker.sv
tb/tb_dense_matrix_multiply_top.sv
